@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types, codes and sequencing functions of the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_SDA  = 5'd1,
    PH_RS_REL  = 5'd2,
    PH_RS_HD   = 5'd3,
    PH_RS_D    = 5'd4,
    PH_RS_SDA  = 5'd5,
    PH_SP_SDA  = 5'd6,
    PH_SP_REL  = 5'd7,
    PH_SP_HD   = 5'd8,
    PH_SP_D    = 5'd9,
    PH_SP_SDA1 = 5'd10,
    PH_WR_BIT  = 5'd11,
    PH_WR_REL  = 5'd12,
    PH_WR_HD   = 5'd13,
    PH_WR_SCL  = 5'd14,
    PH_WR_SDA1 = 5'd15,
    PH_WR_AREL = 5'd16,
    PH_WR_AHD  = 5'd17,
    PH_RD_SDA1 = 5'd18,
    PH_RD_REL  = 5'd19,
    PH_RD_HD   = 5'd20,
    PH_RD_LOW  = 5'd21
  } phase_t;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_RESTART = 3'd1,
    MODE_STOP    = 3'd2,
    MODE_WRITE   = 3'd3,
    MODE_READ    = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NACK    = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_DELAY   = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_CHECK   = 2'd2
  } reg_idx_t;

  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CHAIN_STEPS = 4;
  localparam logic [CFG_W-1:0] DELAY_RST   = 16'd100;
  localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd1000;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] wr_byte;
    logic       scl_in;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    status_t    status;
    logic [7:0] rd_byte;
  } res_t;

  typedef struct packed {
    logic check_en;
    logic d_zero;
  } cfg_ctl_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] bit_idx;
    logic [7:0] shift;
    logic       scl;
    logic       sda;
    logic       done;
    status_t    status;
    logic [7:0] rd;
  } eng_t;

  function automatic logic is_rel(phase_t p);
    return (p == PH_RS_REL) || (p == PH_SP_REL) || (p == PH_WR_REL) ||
           (p == PH_WR_AREL) || (p == PH_RD_REL);
  endfunction

  function automatic eng_t finish_f(eng_t s, status_t st, logic [7:0] rd);
    eng_t r;
    r        = s;
    r.phase  = PH_IDLE;
    r.done   = 1'b1;
    r.status = st;
    r.rd     = rd;
    return r;
  endfunction

  // pin effects on entering a phase
  function automatic eng_t enter_f(eng_t s, phase_t p, logic smp);
    eng_t r;
    r       = s;
    r.phase = p;
    case (p)
      PH_ST_SDA, PH_RS_SDA, PH_SP_SDA: r.sda = 1'b0;
      PH_SP_SDA1, PH_WR_SDA1, PH_RD_SDA1: r.sda = 1'b1;
      PH_WR_BIT: begin
        r.scl = 1'b0;
        r.sda = s.shift[s.bit_idx];
      end
      PH_WR_SCL: r.scl = 1'b0;
      PH_RD_LOW: begin
        r.shift = {s.shift[6:0], smp};
        r.scl   = 1'b0;
      end
      PH_RS_REL, PH_SP_REL, PH_WR_REL, PH_WR_AREL, PH_RD_REL: r.scl = 1'b1;
      default: r.phase = p;
    endcase
    return r;
  endfunction

  // leave the current phase once its wait is over
  function automatic eng_t proceed_f(eng_t s, logic smp);
    eng_t r;
    r = s;
    case (s.phase)
      PH_ST_SDA, PH_RS_SDA: begin
        r.scl = 1'b0;
        r     = finish_f(r, ST_OK, 8'd0);
      end
      PH_RS_REL:  r = enter_f(s, PH_RS_HD, smp);
      PH_RS_HD:   r = enter_f(s, PH_RS_D, smp);
      PH_RS_D:    r = enter_f(s, PH_RS_SDA, smp);
      PH_SP_SDA:  r = enter_f(s, PH_SP_REL, smp);
      PH_SP_REL:  r = enter_f(s, PH_SP_HD, smp);
      PH_SP_HD:   r = enter_f(s, PH_SP_D, smp);
      PH_SP_D:    r = enter_f(s, PH_SP_SDA1, smp);
      PH_SP_SDA1: r = finish_f(s, ST_OK, 8'd0);
      PH_WR_BIT:  r = enter_f(s, PH_WR_REL, smp);
      PH_WR_REL:  r = enter_f(s, PH_WR_HD, smp);
      PH_WR_HD: begin
        if (s.bit_idx != 3'd0) begin
          r.bit_idx = s.bit_idx - 3'd1;
          r         = enter_f(r, PH_WR_BIT, smp);
        end else begin
          r = enter_f(s, PH_WR_SCL, smp);
        end
      end
      PH_WR_SCL:  r = enter_f(s, PH_WR_SDA1, smp);
      PH_WR_SDA1: r = enter_f(s, PH_WR_AREL, smp);
      PH_WR_AREL: r = enter_f(s, PH_WR_AHD, smp);
      PH_WR_AHD: begin
        r.scl = 1'b0;
        r     = finish_f(r, smp ? ST_NACK : ST_OK, 8'd0);
      end
      PH_RD_SDA1: r = enter_f(s, PH_RD_REL, smp);
      PH_RD_REL:  r = enter_f(s, PH_RD_HD, smp);
      PH_RD_HD:   r = enter_f(s, PH_RD_LOW, smp);
      PH_RD_LOW: begin
        if (s.bit_idx != 3'd7) begin
          r.bit_idx = s.bit_idx + 3'd1;
          r         = enter_f(r, PH_RD_REL, smp);
        end else begin
          r = finish_f(s, ST_OK, s.shift);
        end
      end
      default: r.phase = PH_IDLE;
    endcase
    return r;
  endfunction

  // whole command in one tick: no delays and no stretch wait
  function automatic eng_t collapse_f(eng_t s, tick_t t);
    eng_t r;
    r = finish_f(s, ST_OK, 8'd0);
    case (t.mode)
      MODE_START, MODE_RESTART: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
      end
      MODE_STOP: begin
        r.scl = 1'b1;
        r.sda = 1'b1;
      end
      MODE_WRITE: begin
        r.scl     = 1'b0;
        r.sda     = 1'b1;
        r.bit_idx = 3'd0;
        r.shift   = t.wr_byte;
        r.status  = t.sda_in ? ST_NACK : ST_OK;
      end
      MODE_READ: begin
        r.scl     = 1'b0;
        r.sda     = 1'b1;
        r.bit_idx = 3'd7;
        r.shift   = {8{t.sda_in}};
        r.rd      = {8{t.sda_in}};
      end
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/i2cm_cfg.sv @@
// ----------------------------------------------------------------------------
// i2cm_cfg
// configuration registers and the saturated delay and timeout values
// ----------------------------------------------------------------------------
module i2cm_cfg
  import i2cm_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_idx,
  input  logic [CFG_W-1:0]       cfg_wdata,
  output logic [TIMER_WIDTH-1:0] full_d,
  output logic [TIMER_WIDTH-1:0] half_d,
  output logic [TIMER_WIDTH-1:0] tmo,
  output cfg_ctl_t               ctl
);

  localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;

  logic [CFG_W-1:0] delay_r, delay_nxt;
  logic [CFG_W-1:0] tmo_r, tmo_nxt;
  logic             check_r, check_nxt;
  logic [CFG_W:0]   half_raw;

  always_comb begin
    delay_nxt = delay_r;
    tmo_nxt   = tmo_r;
    check_nxt = check_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_DELAY:   delay_nxt = cfg_wdata;
        REG_TIMEOUT: tmo_nxt   = cfg_wdata;
        REG_CHECK:   check_nxt = cfg_wdata[0];
        default:     delay_nxt = delay_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RST;
      tmo_r   <= TIMEOUT_RST;
      check_r <= 1'b1;
    end else begin
      delay_r <= delay_nxt;
      tmo_r   <= tmo_nxt;
      check_r <= check_nxt;
    end
  end

  assign half_raw = (17'(delay_r) + 17'd1) >> 1;

  assign full_d = (33'(delay_r) > TMAX) ? TMAX[TIMER_WIDTH-1:0] : TIMER_WIDTH'(delay_r);
  assign half_d = (33'(half_raw) > TMAX) ? TMAX[TIMER_WIDTH-1:0] : TIMER_WIDTH'(half_raw);
  assign tmo    = (33'(tmo_r) > TMAX) ? TMAX[TIMER_WIDTH-1:0] : TIMER_WIDTH'(tmo_r);

  assign ctl.check_en = check_r;
  assign ctl.d_zero   = (delay_r == '0);

endmodule

@@ rtl/i2cm_core.sv @@
// ----------------------------------------------------------------------------
// i2cm_core
// line sequencer: engine state and the work of one tick
// ----------------------------------------------------------------------------
module i2cm_core
  import i2cm_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  tick_t                  tick,
  input  logic [TIMER_WIDTH-1:0] full_d,
  input  logic [TIMER_WIDTH-1:0] half_d,
  input  logic [TIMER_WIDTH-1:0] tmo,
  input  cfg_ctl_t               ctl,
  output res_t                   res
);

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             bit_idx_r, bit_idx_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic [TIMER_WIDTH-1:0] wait_r, wait_nxt;
  logic [TIMER_WIDTH-1:0] strc_r, strc_nxt;
  logic                   rel_now;

  always_comb begin
    eng_t                   s;
    logic                   fresh;
    logic [TIMER_WIDTH-1:0] wc;
    logic [TIMER_WIDTH-1:0] sc;
    s = '{phase: phase_r, bit_idx: bit_idx_r, shift: shift_r, scl: scl_r, sda: sda_r,
          done: 1'b0, status: ST_OK, rd: 8'd0};
    wc    = wait_r;
    sc    = strc_r;
    fresh = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (tick.cmd_valid && (tick.mode <= MODE_READ)) begin
        if (ctl.d_zero && !ctl.check_en) begin
          s = collapse_f(s, tick);
        end else begin
          fresh = 1'b1;
          case (tick.mode)
            MODE_START: s = enter_f(s, PH_ST_SDA, tick.sda_in);
            MODE_RESTART: begin
              s.sda = 1'b1;
              s     = enter_f(s, PH_RS_REL, tick.sda_in);
            end
            MODE_STOP: s = enter_f(s, PH_SP_SDA, tick.sda_in);
            MODE_WRITE: begin
              s.shift   = tick.wr_byte;
              s.bit_idx = 3'd7;
              s         = enter_f(s, PH_WR_BIT, tick.sda_in);
            end
            default: begin
              s.shift   = 8'd0;
              s.bit_idx = 3'd0;
              s         = enter_f(s, PH_RD_SDA1, tick.sda_in);
            end
          endcase
        end
      end
    end else if (is_rel(phase_r)) begin
      // scl released: wait for the line, count low samples
      if (!ctl.check_en) begin
        s     = proceed_f(s, tick.sda_in);
        fresh = 1'b1;
      end else if (wc != '0) begin
        wc = '0;
      end else if (tick.scl_in) begin
        s     = proceed_f(s, tick.sda_in);
        fresh = 1'b1;
      end else if (sc >= tmo) begin
        fresh = 1'b1;
        priority if (phase_r == PH_RS_REL) begin
          s = enter_f(s, PH_RS_D, tick.sda_in);
        end else if (phase_r == PH_SP_REL) begin
          s = enter_f(s, PH_SP_D, tick.sda_in);
        end else begin
          s = finish_f(s, ST_TIMEOUT, 8'd0);
        end
      end else begin
        sc = sc + TIMER_WIDTH'(1);
      end
    end else if (wc != '0) begin
      wc = wc - TIMER_WIDTH'(1);
    end else begin
      s     = proceed_f(s, tick.sda_in);
      fresh = 1'b1;
    end

    // phases entered during this tick
    for (int k = 0; k < CHAIN_STEPS; k++) begin
      if (fresh && (s.phase != PH_IDLE)) begin
        if (is_rel(s.phase)) begin
          sc = '0;
          if (ctl.check_en) begin
            wc    = '0;
            fresh = 1'b0;
          end else begin
            s = proceed_f(s, tick.sda_in);
          end
        end else if (!ctl.d_zero) begin
          wc    = ((s.phase == PH_SP_SDA1) || (s.phase == PH_RD_LOW)) ?
                  (half_d - TIMER_WIDTH'(1)) : (full_d - TIMER_WIDTH'(1));
          fresh = 1'b0;
        end else begin
          s = proceed_f(s, tick.sda_in);
        end
      end
    end

    phase_nxt   = s.phase;
    bit_idx_nxt = s.bit_idx;
    shift_nxt   = s.shift;
    scl_nxt     = s.scl;
    sda_nxt     = s.sda;
    wait_nxt    = wc;
    strc_nxt    = sc;

    res.scl_out  = s.scl;
    res.sda_out  = s.sda;
    res.busy_res = (s.phase != PH_IDLE);
    res.done_res = s.done;
    res.status   = s.status;
    res.rd_byte  = s.rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_idx_r <= 3'd0;
      shift_r   <= 8'd0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      wait_r    <= '0;
      strc_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      wait_r    <= wait_nxt;
      strc_r    <= strc_nxt;
    end
  end

  assign rel_now = is_rel(phase_r);

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res |=> phase_r == PH_IDLE)
    else $error("engine not idle after a finished command");

  a_rel_scl: assert property (@(posedge clk) disable iff (!rst_n)
    rel_now |-> scl_r)
    else $error("scl held low while waiting for release");

  a_quiet_res: assert property (@(posedge clk) disable iff (!rst_n)
    !res.done_res |-> (res.status == ST_OK) && (res.rd_byte == 8'd0))
    else $error("status or read byte without done");
`endif

endmodule

@@ rtl/i2c_master_bit_engine.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_engine: one tick word accepted per unstalled cycle, one result word per tick
// a tick word goes through the input register, then the tick logic into the result register
// throughput 1 word per cycle while out_tready is high; the sequencer tick logic is combinational
// sync reset: config 100 / 1000 / 1, engine idle with scl and sda released
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
  import i2cm_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cmd_valid, mode[2:0], wr_byte[7:0], scl_in, sda_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl_out, sda_out, busy_res, done_res, status[1:0], rd_byte[7:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  logic                   in_vld_r, in_vld_nxt;
  tick_t                  in_tick_r, in_tick_nxt;
  logic                   out_vld_r, out_vld_nxt;
  res_t                   out_res_r;
  res_t                   res;
  logic                   proc;
  logic [TIMER_WIDTH-1:0] full_d;
  logic [TIMER_WIDTH-1:0] half_d;
  logic [TIMER_WIDTH-1:0] tmo;
  cfg_ctl_t               ctl;

  i2cm_cfg #(.TIMER_WIDTH(TIMER_WIDTH)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .full_d    (full_d),
    .half_d    (half_d),
    .tmo       (tmo),
    .ctl       (ctl)
  );

  i2cm_core #(.TIMER_WIDTH(TIMER_WIDTH)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (proc),
    .tick   (in_tick_r),
    .full_d (full_d),
    .half_d (half_d),
    .tmo    (tmo),
    .ctl    (ctl),
    .res    (res)
  );

  assign proc      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || proc;

  always_comb begin
    in_tick_nxt.cmd_valid = in_tdata[0];
    in_tick_nxt.mode      = in_tdata[3:1];
    in_tick_nxt.wr_byte   = in_tdata[11:4];
    in_tick_nxt.scl_in    = in_tdata[12];
    in_tick_nxt.sda_in    = in_tdata[13];

    in_vld_nxt = in_vld_r;
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
    end else if (proc) begin
      in_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (proc) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_tick_r <= in_tick_nxt;
    end
    if (proc) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_res_r.rd_byte, out_res_r.status, out_res_r.done_res,
                       out_res_r.busy_res, out_res_r.sda_out, out_res_r.scl_out};

`ifndef ASSERT_OFF
  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !proc |=> in_vld_r && $stable(in_tick_r))
    else $error("waiting tick word lost or changed");

  a_proc_out: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> out_vld_r)
    else $error("processed tick gave no result word");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.done_res |-> !out_res_r.busy_res)
    else $error("result word is both done and busy");
`endif

endmodule

@@ tb/i2c_master_bit_engine_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_checker
// watches the tick and result streams and the register port, runs its own
// model of the line engine on every accepted tick word and compares each
// result word field by field with the oldest predicted one
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_checker
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // cmd_valid, mode[2:0], wr_byte[7:0], scl_in, sda_in
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // scl_out, sda_out, busy_res, done_res, status[1:0], rd_byte[7:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  // register copies
  logic [15:0] delay_r;
  logic [15:0] tmo_r;
  logic        check_r;

  // engine copy
  phase_t      ph;
  logic [2:0]  bit_no;
  logic [15:0] hold_cnt;
  logic [15:0] low_cnt;
  logic [7:0]  shreg;
  logic        scl_q;
  logic        sda_q;
  logic        smp_sda;
  logic        done_f;
  status_t     st_f;
  logic [7:0]  rd_f;

  res_t line_results_q[$];
  int   out_words;

  initial begin
    fail_count = 0;
    pending    = 0;
    out_words  = 0;
  end

  function automatic void clear_engine();
    delay_r  = DELAY_RST;
    tmo_r    = TIMEOUT_RST;
    check_r  = 1'b1;
    ph       = PH_IDLE;
    bit_no   = 3'd0;
    hold_cnt = 16'd0;
    low_cnt  = 16'd0;
    shreg    = 8'd0;
    scl_q    = 1'b1;
    sda_q    = 1'b1;
  endfunction

  function automatic logic [15:0] half_delay();
    logic [16:0] sum;
    sum = {1'b0, delay_r} + 17'd1;
    return sum[16:1];
  endfunction

  function automatic logic scl_release(input phase_t p);
    case (p)
      PH_RS_REL, PH_SP_REL, PH_WR_REL, PH_WR_AREL, PH_RD_REL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void complete(input status_t st, input logic [7:0] rd);
    ph     = PH_IDLE;
    done_f = 1'b1;
    st_f   = st;
    rd_f   = rd;
  endfunction

  function automatic void go_to(input phase_t p);
    ph       = p;
    hold_cnt = delay_r;
    case (p)
      PH_ST_SDA, PH_RS_SDA, PH_SP_SDA: sda_q = 1'b0;
      PH_SP_SDA1: begin
        sda_q    = 1'b1;
        hold_cnt = half_delay();
      end
      PH_WR_BIT: begin
        scl_q = 1'b0;
        sda_q = shreg[bit_no];
      end
      PH_WR_SCL: scl_q = 1'b0;
      PH_WR_SDA1, PH_RD_SDA1: sda_q = 1'b1;
      PH_RD_LOW: begin
        shreg    = {shreg[6:0], smp_sda};
        scl_q    = 1'b0;
        hold_cnt = half_delay();
      end
      PH_RS_REL, PH_SP_REL, PH_WR_REL, PH_WR_AREL, PH_RD_REL: begin
        scl_q    = 1'b1;
        low_cnt  = 16'd0;
        hold_cnt = 16'd1;  // release tick does not sample scl
      end
      default: ;
    endcase
  endfunction

  function automatic void step_on();
    case (ph)
      PH_ST_SDA, PH_RS_SDA: begin
        scl_q = 1'b0;
        complete(ST_OK, 8'd0);
      end
      PH_RS_REL:  go_to(PH_RS_HD);
      PH_RS_HD:   go_to(PH_RS_D);
      PH_RS_D:    go_to(PH_RS_SDA);
      PH_SP_SDA:  go_to(PH_SP_REL);
      PH_SP_REL:  go_to(PH_SP_HD);
      PH_SP_HD:   go_to(PH_SP_D);
      PH_SP_D:    go_to(PH_SP_SDA1);
      PH_SP_SDA1: complete(ST_OK, 8'd0);
      PH_WR_BIT:  go_to(PH_WR_REL);
      PH_WR_REL:  go_to(PH_WR_HD);
      PH_WR_HD: begin
        if (bit_no != 3'd0) begin
          bit_no--;
          go_to(PH_WR_BIT);
        end else begin
          go_to(PH_WR_SCL);
        end
      end
      PH_WR_SCL:  go_to(PH_WR_SDA1);
      PH_WR_SDA1: go_to(PH_WR_AREL);
      PH_WR_AREL: go_to(PH_WR_AHD);
      PH_WR_AHD: begin
        scl_q = 1'b0;
        complete(smp_sda ? ST_NACK : ST_OK, 8'd0);
      end
      PH_RD_SDA1: go_to(PH_RD_REL);
      PH_RD_REL:  go_to(PH_RD_HD);
      PH_RD_HD:   go_to(PH_RD_LOW);
      PH_RD_LOW: begin
        if (bit_no < 3'd7) begin
          bit_no++;
          go_to(PH_RD_REL);
        end else begin
          complete(ST_OK, shreg);
        end
      end
      default: ph = PH_IDLE;
    endcase
  endfunction

  // restart and stop skip the delay after the release, the rest give up
  function automatic void timed_out();
    if (ph == PH_RS_REL) go_to(PH_RS_D);
    else if (ph == PH_SP_REL) go_to(PH_SP_D);
    else complete(ST_TIMEOUT, 8'd0);
  endfunction

  function automatic res_t engine_tick(input tick_t t);
    int   n;
    logic stop_loop;
    res_t r;
    smp_sda = t.sda_in;
    done_f  = 1'b0;
    st_f    = ST_OK;
    rd_f    = 8'd0;
    if (ph == PH_IDLE && t.cmd_valid && t.mode <= MODE_READ) begin
      case (t.mode)
        MODE_START: go_to(PH_ST_SDA);
        MODE_RESTART: begin
          sda_q = 1'b1;
          go_to(PH_RS_REL);
        end
        MODE_STOP: go_to(PH_SP_SDA);
        MODE_WRITE: begin
          shreg  = t.wr_byte;
          bit_no = 3'd7;
          go_to(PH_WR_BIT);
        end
        default: begin
          shreg  = 8'd0;
          bit_no = 3'd0;
          go_to(PH_RD_SDA1);
        end
      endcase
    end
    stop_loop = 1'b0;
    for (n = 0; n < 128 && ph != PH_IDLE && !stop_loop; n++) begin
      if (scl_release(ph)) begin
        if (!check_r) step_on();
        else if (hold_cnt != 16'd0) begin
          hold_cnt  = 16'd0;
          stop_loop = 1'b1;
        end else if (t.scl_in) step_on();
        else if (low_cnt >= tmo_r) timed_out();
        else begin
          low_cnt++;
          stop_loop = 1'b1;
        end
      end else if (hold_cnt != 16'd0) begin
        hold_cnt--;
        stop_loop = 1'b1;
      end else begin
        step_on();
      end
    end
    r.scl_out  = scl_q;
    r.sda_out  = sda_q;
    r.busy_res = (ph != PH_IDLE);
    r.done_res = done_f;
    r.status   = st_f;
    r.rd_byte  = rd_f;
    return r;
  endfunction

  function automatic tick_t unpack_tick(input logic [15:0] d);
    tick_t t;
    t.cmd_valid = d[0];
    t.mode      = d[3:1];
    t.wr_byte   = d[11:4];
    t.scl_in    = d[12];
    t.sda_in    = d[13];
    return t;
  endfunction

  function automatic res_t unpack_result(input logic [15:0] d);
    res_t r;
    r.scl_out  = d[0];
    r.sda_out  = d[1];
    r.busy_res = d[2];
    r.done_res = d[3];
    r.status   = status_t'(d[5:4]);
    r.rd_byte  = d[13:6];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (fail_count < 100)
      $display("result word %0d: %s expected %0h got %0h", out_words, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      clear_engine();
      line_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_DELAY:   delay_r = cfg_wdata;
          REG_TIMEOUT: tmo_r   = cfg_wdata;
          REG_CHECK:   check_r = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        line_results_q.push_back(engine_tick(unpack_tick(in_tdata)));
      if (out_tvalid && out_tready) begin
        got = unpack_result(out_tdata);
        if (line_results_q.size() == 0) begin
          report_mismatch("word with nothing expected", 0, out_tdata);
        end else begin
          want = line_results_q.pop_front();
          if (got.scl_out !== want.scl_out)
            report_mismatch("scl_out", want.scl_out, got.scl_out);
          if (got.sda_out !== want.sda_out)
            report_mismatch("sda_out", want.sda_out, got.sda_out);
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", want.busy_res, got.busy_res);
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", want.done_res, got.done_res);
          if (got.status !== want.status)
            report_mismatch("status", want.status, got.status);
          if (got.rd_byte !== want.rd_byte)
            report_mismatch("rd_byte", want.rd_byte, got.rd_byte);
        end
        out_words++;
      end
    end
    pending = line_results_q.size();
  end

endmodule

@@ tb/i2c_master_bit_engine_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// drives tick words into the line engine: a directed run over zero-time
// commands, stretch timeouts, ack and nack, and the longest stretch timeout,
// then random start / write / read / restart / stop transfers with random
// clock stretching, busy commands and random stalls on both streams
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
  import i2cm_pkg::*;

  localparam int ITEMS  = 700;
  localparam int PHASES = 3;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = 16'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [15:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_idx    = REG_DELAY;
  logic [15:0] cfg_wdata  = 16'd0;

  int fail_count;
  int pending;

  int rx_count    = 0;
  bit last_busy   = 1'b0;
  int sent_count  = 0;
  int stall_left  = 0;
  bit idle_en     = 1'b0;
  bit noise_en    = 1'b0;
  int scl_low_pct = 0;
  int sda_one_pct = 50;

  i2c_master_bit_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  i2c_master_bit_engine_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // progress of the result stream
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      rx_count  <= rx_count + 1;
      last_busy <= out_tdata[2];
    end
  end

  function automatic logic [15:0] pack_tick(input tick_t t);
    return {2'b00, t.sda_in, t.scl_in, t.wr_byte, t.mode, t.cmd_valid};
  endfunction

  // tick word with the slave side lines drawn at random
  function automatic tick_t line_tick(input logic valid, input logic [2:0] mode,
                                      input logic [7:0] data);
    tick_t t;
    t.cmd_valid = valid;
    t.mode      = mode;
    t.wr_byte   = data;
    t.scl_in    = ($urandom_range(0, 99) >= scl_low_pct);
    t.sda_in    = ($urandom_range(0, 99) < sda_one_pct);
    return t;
  endfunction

  task automatic send_word(input tick_t t);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_tick(t);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  // offer a command, then keep ticking until the engine reports idle
  task automatic issue(input logic [2:0] mode, input logic [7:0] data);
    int    mark;
    tick_t t;
    send_word(line_tick(1'b1, mode, data));
    mark = sent_count - 1;
    while (!(rx_count > mark && !last_busy)) begin
      if (noise_en && $urandom_range(0, 31) == 0)
        t = line_tick(1'b1, 3'($urandom_range(0, 7)), 8'($urandom));
      else
        t = line_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom));
      send_word(t);
    end
  endtask

  task automatic drain();
    int mark;
    scl_low_pct = 0;
    mark = sent_count - 1;
    while (!(rx_count > mark && !last_busy))
      send_word(line_tick(1'b0, MODE_START, 8'd0));
    in_tvalid <= 1'b0;
    while (rx_count != sent_count || pending != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] dly, input logic [15:0] tmo, input logic chk);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_DELAY;
    cfg_wdata <= dly;
    @(posedge clk);
    cfg_idx   <= REG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_idx   <= REG_CHECK;
    cfg_wdata <= {15'd0, chk};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic bus_transfer();
    int n;
    case ($urandom_range(0, 3))
      0: scl_low_pct = 0;
      1: scl_low_pct = 25;
      2: scl_low_pct = 60;
      default: scl_low_pct = 95;
    endcase
    sda_one_pct = $urandom_range(0, 100);
    if ($urandom_range(0, 6) == 0) begin
      issue(3'($urandom_range(0, 7)), 8'($urandom));
    end else begin
      issue(MODE_START, 8'($urandom));
      n = $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(0, 2) != 0) issue(MODE_WRITE, 8'($urandom));
        else issue(MODE_READ, 8'($urandom));
      end
      if ($urandom_range(0, 3) == 0) begin
        issue(MODE_RESTART, 8'($urandom));
        issue(MODE_WRITE, 8'($urandom));
        issue(MODE_READ, 8'($urandom));
      end
      if ($urandom_range(0, 5) != 0) issue(MODE_STOP, 8'($urandom));
    end
  endtask

  initial begin
    int ph;
    int base;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_en = 1'b1;

    // every command within one tick
    set_regs(16'd0, 16'd0, 1'b0);
    sda_one_pct = 50;
    issue(MODE_START, 8'h00);
    issue(MODE_RESTART, 8'hFF);
    sda_one_pct = 0;
    issue(MODE_WRITE, 8'h00);
    issue(MODE_READ, 8'h00);
    sda_one_pct = 100;
    issue(MODE_WRITE, 8'hFF);
    issue(MODE_READ, 8'hFF);
    issue(MODE_STOP, 8'h00);
    for (int k = MODE_READ + 1; k < 8; k++) issue(3'(k), 8'($urandom));

    // scl held low: timeouts
    set_regs(16'd1, 16'd1, 1'b1);
    sda_one_pct = 50;
    scl_low_pct = 100;
    issue(MODE_WRITE, 8'hA5);
    issue(MODE_READ, 8'h00);
    issue(MODE_RESTART, 8'h00);
    issue(MODE_STOP, 8'h00);
    issue(MODE_START, 8'h00);

    // stretching that resolves, ack then nack
    scl_low_pct = 40;
    sda_one_pct = 0;
    issue(MODE_WRITE, 8'h5A);
    sda_one_pct = 100;
    issue(MODE_WRITE, 8'hC3);
    sda_one_pct = 50;
    issue(MODE_READ, 8'h00);

    // odd half delay, then no stretch check with scl low
    set_regs(16'd3, 16'd0, 1'b1);
    issue(MODE_STOP, 8'h00);
    set_regs(16'd1, 16'd3, 1'b0);
    scl_low_pct = 100;
    issue(MODE_WRITE, 8'h81);
    issue(MODE_READ, 8'h00);

    // longest stretch timeout
    set_regs(16'd0, 16'hFFFF, 1'b1);
    scl_low_pct = 40;
    issue(MODE_WRITE, 8'h3C);

    // random transfers
    noise_en = 1'b1;
    base     = sent_count;
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) idle_en = 1'b0;
      set_regs((ph == 1) ? 16'd2 : 16'($urandom_range(0, 1)),
               16'($urandom_range(0, 3)), ($urandom_range(0, 3) != 0));
      while (sent_count < base + (ITEMS - base) * (ph + 1) / PHASES) bus_transfer();
    end

    noise_en = 1'b0;
    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("i2c_master_bit_engine test passed");
    end else begin
      $display("i2c_master_bit_engine test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("i2c_master_bit_engine test failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/i2cm_pkg.sv
rtl/i2cm_cfg.sv
rtl/i2cm_core.sv
rtl/i2c_master_bit_engine.sv
tb/i2c_master_bit_engine_checker.sv
tb/i2c_master_bit_engine_tb.sv
